FILE: hw/rtl/qrs_pkg.sv
package qrs_pkg;

	localparam int CW = 16;
	localparam int RW = 32;
	localparam int CF = 8;
	localparam int RF = 16;

	localparam int D_W      = 2 * CW + 3;
	localparam int RAD_W    = D_W - 1 + RF;
	localparam int SQ_STEPS = RAD_W / 2;
	localparam int SQRT_W   = SQ_STEPS;
	localparam int NEGB_W   = CW + (RF - CF) + 1;
	localparam int DEN_W    = CW + 1;
	localparam int NUM_W    = SQRT_W + 2;
	localparam int DIV_W    = NUM_W - 1 + CF + 1;
	localparam int QS_W     = DIV_W + 2;

	typedef enum logic [1:0] {
		KIND_REAL      = 2'd0,
		KIND_COMPLEX   = 2'd1,
		KIND_NOT_QUAD  = 2'd2
	} root_kind_t;

	typedef struct packed {
		root_kind_t                kind;
		logic signed [NEGB_W-1:0]  negb;
		logic                      a_neg;
		logic [DEN_W-1:0]          ud;
	} sq_side_t;

	typedef struct packed {
		root_kind_t  kind;
		logic        neg1;
		logic        neg2;
	} dv_side_t;

	typedef struct packed {
		logic signed [RW-1:0]  val;
		logic                  clip;
	} sat_t;

	localparam logic signed [QS_W-1:0] RMAX = {{(QS_W-RW+1){1'b0}}, {(RW-1){1'b1}}};
	localparam logic signed [QS_W-1:0] RMIN = ~RMAX;

	function automatic sat_t sat_root(input logic signed [QS_W-1:0] v);
		sat_t s;
		if (v > RMAX) begin
			s.val  = RMAX[RW-1:0];
			s.clip = 1'b1;
		end else if (v < RMIN) begin
			s.val  = RMIN[RW-1:0];
			s.clip = 1'b1;
		end else begin
			s.val  = v[RW-1:0];
			s.clip = 1'b0;
		end
		return s;
	endfunction

endpackage

FILE: hw/rtl/qrs_if.sv
interface qrs_coef_if;
	import qrs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [CW-1:0]  coef_a;
	logic signed [CW-1:0]  coef_b;
	logic signed [CW-1:0]  coef_c;
	modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if;
	import qrs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [RW-1:0]  root1_re;
	logic signed [RW-1:0]  root1_im;
	logic signed [RW-1:0]  root2_re;
	logic signed [RW-1:0]  root2_im;
	logic [1:0]            root_kind;
	logic                  saturated;
	modport source (output valid, output root1_re, output root1_im, output root2_re,
		output root2_im, output root_kind, output saturated, input ready);
	modport sink (input valid, input root1_re, input root1_im, input root2_re,
		input root2_im, input root_kind, input saturated, output ready);
endinterface

FILE: hw/rtl/quadratic_root_solver_top.sv
// quadratic root solver: both roots of a*x^2 + b*x + c = 0 as complex numbers
// coef channel: one transaction carries coef_a, coef_b, coef_c in signed Q8.8
// roots channel: one transaction per equation with root1/root2 real and
// imaginary parts in signed Q16.16, root_kind (0 real, 1 complex pair,
// 2 a is zero with all roots zero) and saturated when a part was clipped
// the pipeline has two multiply and discriminant stages, 25 square root
// stages (one result bit each), one numerator stage, 35 divider stages (one
// quotient bit each) and the rounding and saturation output register
// throughput is one equation per cycle unless stalled; every stage has its own
// valid bit and takes new data when it is empty or its successor moves on
// when the receiver stalls, results pile up stage by stage behind the
// output register and coef ready drops only once the first stage is full
// reset clears all valid bits; no transaction is in flight afterwards
module quadratic_root_solver_top (
	input  logic         clk,
	input  logic         arst_n,
	qrs_coef_if.sink     coef,
	qrs_root_if.source   roots
);
	import qrs_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4;
	logic sq_in_ready, sq_out_valid, dv_in_ready, dv_out_valid;

	logic                  v_s1;
	logic signed [CW-1:0]  a_s1;
	logic signed [CW-1:0]  b_s1;
	logic signed [2*CW-1:0] bb_s1;
	logic signed [2*CW-1:0] ac_s1;

	logic                  v_s2;
	logic [RAD_W-1:0]      rad_s2;
	sq_side_t              side_s2;

	logic                  v_s3;
	logic [DIV_W-1:0]      dvd1_s3;
	logic [DIV_W-1:0]      dvd2_s3;
	logic [DEN_W-1:0]      ud_s3;
	dv_side_t              side_s3;

	logic                  v_s4;
	logic signed [RW-1:0]  r1re_s4, r1im_s4, r2re_s4, r2im_s4;
	root_kind_t            kind_s4;
	logic                  sat_s4;

	logic [SQRT_W-1:0]     sq_root;
	sq_side_t              sq_side;
	logic [DIV_W-1:0]      quo1, quo2;
	dv_side_t              dv_side;

	assign en_s4 = !v_s4 || roots.ready;
	assign en_s3 = !v_s3 || dv_in_ready;
	assign en_s2 = !v_s2 || sq_in_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign coef.ready = en_s1;

	// products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1  <= coef.coef_a;
			b_s1  <= coef.coef_b;
			bb_s1 <= coef.coef_b * coef.coef_b;
			ac_s1 <= coef.coef_a * coef.coef_c;
		end
	end

	// discriminant and operand prep
	logic signed [D_W-1:0]    d;
	logic signed [D_W-1:0]    dmag;
	logic signed [DEN_W-1:0]  a2;
	logic signed [DEN_W-1:0]  a2mag;
	sq_side_t                 side_d;

	always_comb begin
		d     = D_W'(bb_s1) - (D_W'(ac_s1) <<< 2);
		dmag  = d[D_W-1] ? -d : d;
		a2    = DEN_W'(a_s1) <<< 1;
		a2mag = a2[DEN_W-1] ? -a2 : a2;
		if (a_s1 == '0) begin
			side_d.kind = KIND_NOT_QUAD;
		end else if (d[D_W-1]) begin
			side_d.kind = KIND_COMPLEX;
		end else begin
			side_d.kind = KIND_REAL;
		end
		side_d.negb  = -(NEGB_W'(b_s1) <<< (RF - CF));
		side_d.a_neg = a_s1[CW-1];
		side_d.ud    = a2mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rad_s2  <= {dmag[D_W-2:0], {RF{1'b0}}};
			side_s2 <= side_d;
		end
	end

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (sq_in_ready),
		.rad       (rad_s2),
		.in_side   (side_s2),
		.out_valid (sq_out_valid),
		.out_ready (en_s3),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// numerators
	logic signed [NUM_W-1:0]  s_ext, nb_ext, num1, num2;
	logic [NUM_W-2:0]         mag1, mag2;
	dv_side_t                 side_n;

	always_comb begin
		s_ext  = NUM_W'(sq_root);
		nb_ext = NUM_W'(sq_side.negb);
		if (sq_side.kind == KIND_REAL) begin
			num1 = nb_ext + s_ext;
			num2 = nb_ext - s_ext;
		end else begin
			num1 = nb_ext;
			num2 = -s_ext;
		end
		mag1 = num1[NUM_W-1] ? (NUM_W-1)'(-num1) : num1[NUM_W-2:0];
		mag2 = num2[NUM_W-1] ? (NUM_W-1)'(-num2) : num2[NUM_W-2:0];
		side_n.kind = sq_side.kind;
		side_n.neg1 = num1[NUM_W-1] ^ sq_side.a_neg;
		side_n.neg2 = num2[NUM_W-1] ^ sq_side.a_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= sq_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			dvd1_s3 <= DIV_W'({mag1, {CF{1'b0}}}) + DIV_W'(sq_side.ud >> 1);
			dvd2_s3 <= DIV_W'({mag2, {CF{1'b0}}}) + DIV_W'(sq_side.ud >> 1);
			ud_s3   <= sq_side.ud;
			side_s3 <= side_n;
		end
	end

	qrs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (dv_in_ready),
		.dvd1      (dvd1_s3),
		.dvd2      (dvd2_s3),
		.dvs       (ud_s3),
		.in_side   (side_s3),
		.out_valid (dv_out_valid),
		.out_ready (en_s4),
		.quo1      (quo1),
		.quo2      (quo2),
		.out_side  (dv_side)
	);

	// sign, saturation, output register
	logic signed [QS_W-1:0]  q1s, q2s;
	sat_t                    sat1, sat2, sat2n;

	always_comb begin
		q1s   = dv_side.neg1 ? -QS_W'(quo1) : QS_W'(quo1);
		q2s   = dv_side.neg2 ? -QS_W'(quo2) : QS_W'(quo2);
		sat1  = sat_root(q1s);
		sat2  = sat_root(q2s);
		sat2n = sat_root(-q2s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= dv_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			kind_s4 <= dv_side.kind;
			case (dv_side.kind)
				KIND_REAL: begin
					r1re_s4 <= sat1.val;
					r1im_s4 <= '0;
					r2re_s4 <= sat2.val;
					r2im_s4 <= '0;
					sat_s4  <= sat1.clip | sat2.clip;
				end
				KIND_COMPLEX: begin
					r1re_s4 <= sat1.val;
					r1im_s4 <= sat2.val;
					r2re_s4 <= sat1.val;
					r2im_s4 <= sat2n.val;
					sat_s4  <= sat1.clip | sat2.clip | sat2n.clip;
				end
				default: begin
					r1re_s4 <= '0;
					r1im_s4 <= '0;
					r2re_s4 <= '0;
					r2im_s4 <= '0;
					sat_s4  <= 1'b0;
				end
			endcase
		end
	end

	assign roots.valid     = v_s4;
	assign roots.root1_re  = r1re_s4;
	assign roots.root1_im  = r1im_s4;
	assign roots.root2_re  = r2re_s4;
	assign roots.root2_im  = r2im_s4;
	assign roots.root_kind = kind_s4;
	assign roots.saturated = sat_s4;

	a_not_quad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && kind_s4 == KIND_NOT_QUAD) |->
		(r1re_s4 == '0 && r1im_s4 == '0 && r2re_s4 == '0 && r2im_s4 == '0 && !sat_s4))
		else $error("not quadratic result with nonzero roots");

	a_real_no_im: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && kind_s4 == KIND_REAL) |-> (r1im_s4 == '0 && r2im_s4 == '0))
		else $error("real roots with imaginary part");

	a_conj_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && kind_s4 == KIND_COMPLEX && !sat_s4) |->
		(r1re_s4 == r2re_s4 && r2im_s4 == -r1im_s4))
		else $error("complex roots not conjugate");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!coef.ready |-> (v_s1 && v_s2))
		else $error("input stalled with empty front stages");

endmodule

FILE: hw/rtl/qrs_sqrt.sv
module qrs_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [qrs_pkg::RAD_W-1:0]     rad,
	input  qrs_pkg::sq_side_t             in_side,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [qrs_pkg::SQRT_W-1:0]    root,
	output qrs_pkg::sq_side_t             out_side
);
	import qrs_pkg::*;

	logic [SQ_STEPS-1:0]  v_s;
	logic [SQ_STEPS:0]    en;
	logic [RAD_W-1:0]     rem_s [SQ_STEPS];
	logic [RAD_W-1:0]     r_s [SQ_STEPS];
	sq_side_t             side_s [SQ_STEPS];

	always_comb begin
		en[SQ_STEPS] = out_ready;
		for (int k = SQ_STEPS - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [RAD_W-1:0] BITV = (RAD_W)'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [RAD_W-1:0]  vin;
		logic [RAD_W-1:0]  rin;
		logic [RAD_W-1:0]  t;
		logic              vld;
		sq_side_t          sin;

		if (k == 0) begin : g_first
			assign vin = rad;
			assign rin = '0;
			assign vld = in_valid;
			assign sin = in_side;
		end else begin : g_next
			assign vin = rem_s[k-1];
			assign rin = r_s[k-1];
			assign vld = v_s[k-1];
			assign sin = side_s[k-1];
		end

		assign t = rin + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				side_s[k] <= sin;
				if (vin >= t) begin
					rem_s[k] <= vin - t;
					r_s[k]   <= (rin >> 1) + BITV;
				end else begin
					rem_s[k] <= vin;
					r_s[k]   <= rin >> 1;
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[SQ_STEPS-1];
	assign root      = r_s[SQ_STEPS-1][SQRT_W-1:0];
	assign out_side  = side_s[SQ_STEPS-1];

endmodule

FILE: hw/rtl/qrs_div.sv
module qrs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [qrs_pkg::DIV_W-1:0]    dvd1,
	input  logic [qrs_pkg::DIV_W-1:0]    dvd2,
	input  logic [qrs_pkg::DEN_W-1:0]    dvs,
	input  qrs_pkg::dv_side_t            in_side,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [qrs_pkg::DIV_W-1:0]    quo1,
	output logic [qrs_pkg::DIV_W-1:0]    quo2,
	output qrs_pkg::dv_side_t            out_side
);
	import qrs_pkg::*;

	logic [DIV_W-1:0]  v_s;
	logic [DIV_W:0]    en;
	logic [DEN_W-1:0]  rem1_s [DIV_W];
	logic [DEN_W-1:0]  rem2_s [DIV_W];
	logic [DIV_W-1:0]  dq1_s [DIV_W];
	logic [DIV_W-1:0]  dq2_s [DIV_W];
	logic [DEN_W-1:0]  ud_s [DIV_W];
	dv_side_t          side_s [DIV_W];

	always_comb begin
		en[DIV_W] = out_ready;
		for (int k = DIV_W - 1; k >= 0; k--) begin
			en[k] = !v_s[k] || en[k+1];
		end
	end

	for (genvar k = 0; k < DIV_W; k++) begin : g_step
		logic [DEN_W-1:0]  r1in;
		logic [DEN_W-1:0]  r2in;
		logic [DIV_W-1:0]  q1in;
		logic [DIV_W-1:0]  q2in;
		logic [DEN_W-1:0]  udin;
		logic              vld;
		dv_side_t          sin;
		logic [DEN_W:0]    t1;
		logic [DEN_W:0]    t2;
		logic              ge1;
		logic              ge2;

		if (k == 0) begin : g_first
			assign r1in = '0;
			assign r2in = '0;
			assign q1in = dvd1;
			assign q2in = dvd2;
			assign udin = dvs;
			assign vld  = in_valid;
			assign sin  = in_side;
		end else begin : g_next
			assign r1in = rem1_s[k-1];
			assign r2in = rem2_s[k-1];
			assign q1in = dq1_s[k-1];
			assign q2in = dq2_s[k-1];
			assign udin = ud_s[k-1];
			assign vld  = v_s[k-1];
			assign sin  = side_s[k-1];
		end

		assign t1  = {r1in, q1in[DIV_W-1]};
		assign t2  = {r2in, q2in[DIV_W-1]};
		assign ge1 = t1 >= {1'b0, udin};
		assign ge2 = t2 >= {1'b0, udin};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				ud_s[k]   <= udin;
				side_s[k] <= sin;
				rem1_s[k] <= ge1 ? DEN_W'(t1 - {1'b0, udin}) : t1[DEN_W-1:0];
				rem2_s[k] <= ge2 ? DEN_W'(t2 - {1'b0, udin}) : t2[DEN_W-1:0];
				dq1_s[k]  <= {q1in[DIV_W-2:0], ge1};
				dq2_s[k]  <= {q2in[DIV_W-2:0], ge2};
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[DIV_W-1];
	assign quo1      = dq1_s[DIV_W-1];
	assign quo2      = dq2_s[DIV_W-1];
	assign out_side  = side_s[DIV_W-1];

endmodule
